FILE: src/lhc_pkg.sv
// Package for the LFU heap cache: sizes, status codes, FSM states and the
// controller/datapath command and status structs. No dependencies.
package lhc_pkg;
  localparam int MaxEntries  = 16;
  localparam int KeyBits     = 16;
  localparam int PayloadBits = 32;
  localparam int CountBits   = 16;
  localparam int IdxBits     = $clog2(MaxEntries);
  localparam int FillBits    = $clog2(MaxEntries + 1);
  localparam int CapBits     = 5;
  localparam int StatusBits  = 3;
  localparam logic [CapBits-1:0] CapReset = CapBits'(4);

  localparam logic [StatusBits-1:0] ST_HIT       = 3'd0;
  localparam logic [StatusBits-1:0] ST_MISS      = 3'd1;
  localparam logic [StatusBits-1:0] ST_INS       = 3'd2;
  localparam logic [StatusBits-1:0] ST_INS_EVICT = 3'd3;
  localparam logic [StatusBits-1:0] ST_DUP       = 3'd4;

  typedef logic [KeyBits-1:0]     key_t;
  typedef logic [PayloadBits-1:0] pay_t;
  typedef logic [CountBits-1:0]   cnt_t;
  typedef logic [IdxBits-1:0]     idx_t;
  typedef logic [FillBits-1:0]    fill_t;

  typedef struct packed {
    key_t key;
    cnt_t cnt;
    pay_t pay;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_EVICT, S_DN_RD, S_DN_CMP,
    S_APPEND, S_UP_RD, S_UP_CMP, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_SCAN, OP_HIT, OP_MISS, OP_DUP,
    OP_EV_RD, OP_EVICT, OP_DN_RD, OP_DN_SWAP, OP_DN_END,
    OP_APPEND, OP_UP_RD, OP_UP_SWAP, OP_UP_END
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic   is_insert;
    logic   scan_done;
    logic   found;
    logic   full;
    logic   dn_swap;
    logic   dn_last;
    logic   up_swap;
    logic   up_last;
    logic   after_evict;
    logic   room;
  } stat_t;
endpackage

FILE: src/lhc_if.sv
// Valid/ready channel interfaces for the LFU heap cache.
// Depends on lhc_pkg.
interface lhc_req_if;
  import lhc_pkg::*;
  logic valid;
  logic ready;
  logic command;
  key_t item_key;
  pay_t item_payload;
  modport source (output valid, command, item_key, item_payload, input ready);
  modport sink   (input valid, command, item_key, item_payload, output ready);
endinterface

interface lhc_rsp_if;
  import lhc_pkg::*;
  logic valid;
  logic ready;
  logic [StatusBits-1:0] status;
  pay_t payload_out;
  cnt_t use_count;
  key_t evicted_key;
  modport source (output valid, status, payload_out, use_count, evicted_key,
                  input ready);
  modport sink   (input valid, status, payload_out, use_count, evicted_key,
                  output ready);
endinterface

interface lhc_cfg_if;
  import lhc_pkg::*;
  logic valid;
  logic ready;
  logic [CapBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/lhc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lhc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/lhc_datapath.sv
// Datapath: heap RAMs, key scan, sift cursor, fill count and result registers.
// Depends on lhc_pkg and lhc_ram.
module lhc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lhc_pkg::cmd_t              cmd,
  output lhc_pkg::stat_t             stat,
  input  logic                       in_command,
  input  lhc_pkg::key_t              in_key,
  input  lhc_pkg::pay_t              in_payload,
  input  logic [lhc_pkg::CapBits-1:0] cap,
  output logic [lhc_pkg::StatusBits-1:0] res_status,
  output lhc_pkg::pay_t              res_payload,
  output lhc_pkg::cnt_t              res_count,
  output lhc_pkg::key_t              res_evicted
);
  import lhc_pkg::*;

  // Request capture and working registers
  logic   cmd_r;
  key_t   key_r;
  pay_t   pay_r;
  fill_t  held_r;
  fill_t  scan_r;
  logic   vld_r;    // ra_data holds a live entry from slot at_r
  idx_t   at_r;
  idx_t   pos_r;
  entry_t cur_r;    // entry being sifted, written back once it settles
  logic   evicted_r;
  logic [StatusBits-1:0] status_r;
  pay_t   payout_r;
  cnt_t   count_r;
  key_t   evkey_r;

  // Heap RAMs: two copies share the write port to give two read ports
  logic   we;
  idx_t   waddr;
  entry_t wdata;
  idx_t   ra_addr, rb_addr;
  entry_t ra_data, rb_data;

  lhc_ram #(.Width($bits(entry_t)), .Depth(MaxEntries)) u_ram_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(ra_addr), .rdata(ra_data));
  lhc_ram #(.Width($bits(entry_t)), .Depth(MaxEntries)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(rb_addr), .rdata(rb_data));

  // Effective capacity clamp
  fill_t cap_eff;
  always_comb begin
    if (cap == '0) cap_eff = fill_t'(1);
    else if (cap > CapBits'(MaxEntries)) cap_eff = fill_t'(MaxEntries);
    else cap_eff = fill_t'(cap);
  end

  // Child/parent indexes of the cursor
  logic [IdxBits+1:0] lidx, ridx;
  idx_t lpos, rpos, pidx, last;
  assign lidx = {1'b0, pos_r, 1'b1};
  assign ridx = {1'b0, pos_r, 1'b0} + (IdxBits+2)'(2);
  assign lpos = lidx[IdxBits-1:0];
  assign rpos = ridx[IdxBits-1:0];
  assign pidx = (pos_r - idx_t'(1)) >> 1;
  assign last = idx_t'(held_r - fill_t'(1));

  logic l_ok, r_ok, room;
  assign l_ok = lidx < (IdxBits+2)'(held_r);
  assign r_ok = ridx < (IdxBits+2)'(held_r);
  assign room = held_r < fill_t'(MaxEntries);

  // Sift-down choice: smaller child, left on ties
  logic go_l, go_r;
  always_comb begin
    go_l = l_ok && (ra_data.cnt < cur_r.cnt);
    go_r = r_ok && (rb_data.cnt < (go_l ? ra_data.cnt : cur_r.cnt));
  end

  // Saturating count bump on a hit
  cnt_t bump_cnt;
  assign bump_cnt = (ra_data.cnt == '1) ? ra_data.cnt : ra_data.cnt + cnt_t'(1);

  // Status to the controller
  always_comb begin
    stat.is_insert   = cmd_r;
    stat.scan_done   = !vld_r && (scan_r != '0);
    stat.found       = vld_r && (ra_data.key == key_r);
    stat.full        = (held_r >= cap_eff) && (held_r != '0);
    stat.dn_swap     = go_l || go_r;
    stat.dn_last     = !l_ok;
    stat.up_swap     = ra_data.cnt > cur_r.cnt;
    stat.up_last     = (pos_r == '0);
    stat.after_evict = evicted_r;
    stat.room        = room;
  end

  // Read addresses
  always_comb begin
    ra_addr = scan_r[IdxBits-1:0];
    rb_addr = rpos;
    case (cmd.op)
      OP_DN_RD: begin
        ra_addr = lpos;
        rb_addr = rpos;
      end
      OP_UP_RD: ra_addr = pidx;
      OP_EV_RD: begin
        ra_addr = '0;
        rb_addr = last;
      end
      default: ;
    endcase
  end

  // Write port: a swap writes the moved neighbor, the cursor goes back at the end
  always_comb begin
    we = 1'b0;
    waddr = pos_r;
    wdata = cur_r;
    case (cmd.op)
      OP_DN_SWAP: begin
        we = 1'b1;
        wdata = go_r ? rb_data : ra_data;
      end
      OP_UP_SWAP: begin
        we = 1'b1;
        wdata = ra_data;
      end
      OP_DN_END, OP_UP_END: we = 1'b1;
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r     <= 1'b0;
      key_r     <= '0;
      pay_r     <= '0;
      held_r    <= '0;
      scan_r    <= '0;
      vld_r     <= 1'b0;
      at_r      <= '0;
      pos_r     <= '0;
      cur_r     <= '0;
      evicted_r <= 1'b0;
      status_r  <= ST_MISS;
      payout_r  <= '0;
      count_r   <= '0;
      evkey_r   <= '0;
    end else begin
      case (cmd.op)
        OP_START: begin
          cmd_r <= in_command; key_r <= in_key; pay_r <= in_payload;
          scan_r <= '0; vld_r <= 1'b0; evicted_r <= 1'b0;
          payout_r <= '0; count_r <= '0; evkey_r <= '0;
        end
        OP_SCAN: begin
          scan_r <= scan_r + fill_t'(1);
          vld_r <= scan_r < held_r;
          at_r <= scan_r[IdxBits-1:0];
        end
        OP_HIT: begin
          pos_r <= at_r;
          cur_r <= {ra_data.key, bump_cnt, ra_data.pay};
          status_r <= ST_HIT;
        end
        OP_MISS: status_r <= ST_MISS;
        OP_DUP:  status_r <= ST_DUP;
        OP_EVICT: begin
          // root read on port A, last entry on port B
          evkey_r <= ra_data.key;
          cur_r <= rb_data;
          held_r <= held_r - fill_t'(1);
          pos_r <= '0;
          evicted_r <= 1'b1;
        end
        OP_DN_SWAP: pos_r <= go_r ? rpos : lpos;
        OP_DN_END: begin
          if (!evicted_r) begin
            payout_r <= cur_r.pay;
            count_r <= cur_r.cnt;
          end
        end
        OP_APPEND: begin
          status_r <= evicted_r ? ST_INS_EVICT : ST_INS;
          count_r <= cnt_t'(1);
          if (room) begin
            pos_r <= held_r[IdxBits-1:0];
            cur_r <= {key_r, cnt_t'(1), pay_r};
            held_r <= held_r + fill_t'(1);
          end
        end
        OP_UP_SWAP: pos_r <= pidx;
        default: ;
      endcase
    end
  end

  assign res_status  = status_r;
  assign res_payload = payout_r;
  assign res_count   = count_r;
  assign res_evicted = evkey_r;
endmodule

FILE: src/lhc_ctrl.sv
// Controller state machine for the LFU heap cache.
// Depends on lhc_pkg.
module lhc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lhc_pkg::stat_t stat,
  output lhc_pkg::cmd_t  cmd
);
  import lhc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_START;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // one slot read per cycle, compared in the following cycle
        if (stat.found) begin
          if (stat.is_insert) begin
            cmd.op = OP_DUP;
            state_nxt = S_OUT;
          end else begin
            cmd.op = OP_HIT;
            state_nxt = S_DN_RD;
          end
        end else if (stat.scan_done) begin
          if (!stat.is_insert) begin
            cmd.op = OP_MISS;
            state_nxt = S_OUT;
          end else if (stat.full) begin
            cmd.op = OP_EV_RD;
            state_nxt = S_EVICT;
          end else state_nxt = S_APPEND;
        end else cmd.op = OP_SCAN;
      end
      S_EVICT: begin
        cmd.op = OP_EVICT;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.dn_last) begin
          cmd.op = OP_DN_END;
          state_nxt = stat.after_evict ? S_APPEND : S_OUT;
        end else begin
          cmd.op = OP_DN_RD;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_swap) begin
          cmd.op = OP_DN_SWAP;
          state_nxt = S_DN_RD;
        end else begin
          cmd.op = OP_DN_END;
          state_nxt = stat.after_evict ? S_APPEND : S_OUT;
        end
      end
      S_APPEND: begin
        cmd.op = OP_APPEND;
        state_nxt = stat.room ? S_UP_RD : S_OUT;
      end
      S_UP_RD: begin
        if (stat.up_last) begin
          cmd.op = OP_UP_END;
          state_nxt = S_OUT;
        end else begin
          cmd.op = OP_UP_RD;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_swap) begin
          cmd.op = OP_UP_SWAP;
          state_nxt = S_UP_RD;
        end else begin
          cmd.op = OP_UP_END;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_hs_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready) else $error("no return to idle");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

FILE: src/lfu_heap_cache.sv
// Top level of the LFU heap cache: controller, datapath, config register.
// Depends on lhc_pkg, lhc_if, lhc_ctrl, lhc_datapath.
// Flow: a key scan over the held entries after accept, then sift steps through
// the heap levels: down on a hit or eviction, up after an insert's append.
// One request at a time: the next is accepted only after the result is taken.
// Reset (rst_n low, synchronous) empties the cache and sets capacity to 4.
module lfu_heap_cache (
  input logic      clk,
  input logic      rst_n,
  lhc_req_if.sink  in_ch,
  lhc_rsp_if.source out_ch,
  lhc_cfg_if.sink  cfg_ch
);
  import lhc_pkg::*;

  logic [CapBits-1:0] cap_r;
  cmd_t  cmd;
  stat_t stat;

  // Capacity register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CapReset;
    else if (cfg_ch.valid) cap_r <= cfg_ch.data;
  end

  lhc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd));

  lhc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command(in_ch.command), .in_key(in_ch.item_key),
    .in_payload(in_ch.item_payload), .cap(cap_r),
    .res_status(out_ch.status), .res_payload(out_ch.payload_out),
    .res_count(out_ch.use_count), .res_evicted(out_ch.evicted_key));
endmodule

FILE: tb/lfu_heap_cache_tb.sv
// Self-checking testbench for the LFU heap cache: lookups and inserts with
// random handshake gaps, predicted against a behavioral min-heap cache.
// Depends on lhc_pkg, lhc_if and lfu_heap_cache.
module lfu_heap_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lhc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 60;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic command;
    key_t key;
    pay_t pay;
  } request_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    pay_t pay;
    cnt_t cnt;
    key_t evicted;
  } response_t;

  logic clk;
  logic rst_n;

  lhc_req_if in_ch ();
  lhc_rsp_if out_ch ();
  lhc_cfg_if cfg_ch ();

  lfu_heap_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Cache shadow
  key_t  sh_keys [MaxEntries];
  cnt_t  sh_cnts [MaxEntries];
  pay_t  sh_pays [MaxEntries];
  int    sh_fill = 0;
  int    sh_cap;

  request_t  pending_reqs [$];
  response_t expected_rsps [$];
  key_t      known_keys [$];
  int        errors = 0;
  int        cycles = 0;
  bit        hold_go;
  bit        holding;
  bit        in_acc;
  bit        out_acc;
  int        caps [6] = '{16, 1, 7, 0, 31, 3};

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("lfu_heap_cache_tb NOT OK");
      $finish;
    end
  end

  function automatic void swap_entries(int a, int b);
    key_t k;
    cnt_t c;
    pay_t p;
    k = sh_keys[a]; sh_keys[a] = sh_keys[b]; sh_keys[b] = k;
    c = sh_cnts[a]; sh_cnts[a] = sh_cnts[b]; sh_cnts[b] = c;
    p = sh_pays[a]; sh_pays[a] = sh_pays[b]; sh_pays[b] = p;
  endfunction

  function automatic int heap_sink(int pos);
    int best;
    best = pos;
    forever begin
      if (2*pos+1 < sh_fill && sh_cnts[2*pos+1] < sh_cnts[pos]) best = 2*pos+1;
      if (2*pos+2 < sh_fill && sh_cnts[2*pos+2] < sh_cnts[best]) best = 2*pos+2;
      if (best == pos) return pos;
      swap_entries(pos, best);
      pos = best;
    end
  endfunction

  function automatic int find_entry(key_t key);
    for (int i = 0; i < sh_fill; i++) if (sh_keys[i] == key) return i;
    return -1;
  endfunction

  // Predict the response of one request and update the shadow heap
  function automatic response_t cache_access(request_t r);
    response_t rsp;
    int pos;
    int cap;
    rsp = '0;
    pos = find_entry(r.key);
    cap = (sh_cap < 1) ? 1 : (sh_cap > MaxEntries ? MaxEntries : sh_cap);
    if (!r.command) begin
      if (pos < 0) begin
        rsp.status = ST_MISS;
      end else begin
        if (sh_cnts[pos] != '1) sh_cnts[pos] = sh_cnts[pos] + 1'b1;
        pos = heap_sink(pos);
        rsp.status = ST_HIT;
        rsp.pay = sh_pays[pos];
        rsp.cnt = sh_cnts[pos];
      end
    end else if (pos >= 0) begin
      rsp.status = ST_DUP;
    end else begin
      rsp.status = ST_INS;
      if (sh_fill >= cap && sh_fill > 0) begin
        rsp.evicted = sh_keys[0];
        sh_keys[0] = sh_keys[sh_fill-1];
        sh_cnts[0] = sh_cnts[sh_fill-1];
        sh_pays[0] = sh_pays[sh_fill-1];
        sh_fill--;
        void'(heap_sink(0));
        rsp.status = ST_INS_EVICT;
      end
      if (sh_fill < MaxEntries) begin
        pos = sh_fill;
        sh_keys[pos] = r.key;
        sh_cnts[pos] = cnt_t'(1);
        sh_pays[pos] = r.pay;
        sh_fill++;
        while (pos > 0 && sh_cnts[(pos-1)/2] > sh_cnts[pos]) begin
          swap_entries(pos, (pos-1)/2);
          pos = (pos-1)/2;
        end
      end
      rsp.cnt = cnt_t'(1);
    end
    return rsp;
  endfunction

  // Request driver
  int gap_in;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= 1'b0;
      in_ch.item_key <= '0;
      in_ch.item_payload <= '0;
      gap_in <= 0;
    end else if (in_ch.valid && !in_acc) begin
      // hold the request until it is taken
    end else if (gap_in > 0) begin
      in_ch.valid <= 1'b0;
      gap_in <= gap_in - 1;
    end else if (pending_reqs.size() > 0) begin
      in_ch.valid <= 1'b1;
      {in_ch.command, in_ch.item_key, in_ch.item_payload} <= pending_reqs.pop_front();
      gap_in <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Predict on acceptance
  always @(posedge clk) begin
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_rsps.insert(expected_rsps.size(),
                           cache_access({in_ch.command, in_ch.item_key,
                                         in_ch.item_payload}));
  end

  // Long receiver hold-off, counted here
  initial begin
    holding = 1'b0;
    wait (hold_go);
    @(negedge clk);
    holding <= 1'b1;
    repeat (HoldCycles) @(negedge clk);
    holding <= 1'b0;
  end

  // Response sink: a random wait after each response, plus the hold-off
  int gap_out;
  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      gap_out <= 0;
    end else if (holding) begin
      out_ch.ready <= 1'b0;
    end else if (out_acc) begin
      g = $urandom_range(0, 7);
      out_ch.ready <= (g == 0);
      gap_out <= (g == 0) ? 0 : g - 1;
    end else if (gap_out > 0) begin
      out_ch.ready <= 1'b0;
      gap_out <= gap_out - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Response monitor
  always @(posedge clk) begin
    response_t want;
    out_acc <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response status=%0d", $realtime, out_ch.status);
        errors <= errors + 1;
      end else begin
        want = expected_rsps.pop_front();
        if (out_ch.status !== want.status || out_ch.payload_out !== want.pay ||
            out_ch.use_count !== want.cnt || out_ch.evicted_key !== want.evicted) begin
          $display("%0t: expected st=%0d pay=%h cnt=%0d ev=%h, got st=%0d pay=%h cnt=%0d ev=%h",
                   $realtime, want.status, want.pay, want.cnt, want.evicted,
                   out_ch.status, out_ch.payload_out, out_ch.use_count,
                   out_ch.evicted_key);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_capacity(int cap);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= cap[CapBits-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sh_cap = cap;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic key_t pick_key();
    if (known_keys.size() > 0 && $urandom_range(0, 9) < 7)
      return known_keys[$urandom_range(0, known_keys.size()-1)];
    return key_t'($urandom);
  endfunction

  task automatic queue_req(logic cmd, key_t key, pay_t pay);
    pending_reqs.insert(pending_reqs.size(), {cmd, key, pay});
    if (cmd) known_keys.insert(known_keys.size(), key);
    if (known_keys.size() > 24) void'(known_keys.pop_front());
  endtask

  task automatic random_phase(int n);
    key_t k;
    for (int i = 0; i < n; i++) begin
      k = pick_key();
      // mostly miss-then-insert pairs and hits on live keys
      if ($urandom_range(0, 2) == 0) begin
        queue_req(1'b0, k, $urandom);
        queue_req(1'b1, k, $urandom);
        i++;
      end else begin
        queue_req(1'($urandom_range(0, 3) == 0), k, $urandom);
      end
    end
  endtask

  initial begin
    sh_cap = 4;
    hold_go = 1'b0;
    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, miss, duplicate, eviction at reset capacity
    queue_req(1'b0, 16'h0000, '0);
    queue_req(1'b1, 16'h0000, 32'hFFFF_FFFF);
    queue_req(1'b1, 16'hFFFF, 32'h0000_0000);
    queue_req(1'b1, 16'hFFFF, 32'h1234_5678);
    queue_req(1'b0, 16'hFFFF, '1);
    queue_req(1'b0, 16'h0000, '0);
    queue_req(1'b1, 16'h5A5A, 32'hA5A5_A5A5);
    queue_req(1'b1, 16'hA5A5, 32'h5A5A_5A5A);
    queue_req(1'b1, 16'h0001, 32'h0000_0001);
    queue_req(1'b1, 16'h8000, 32'h8000_0000);
    queue_req(1'b0, 16'h1111, '0);
    wait_idle();

    // Lower capacity below the fill, then insert
    write_capacity(2);
    queue_req(1'b1, 16'h2222, 32'hDEAD_BEEF);
    queue_req(1'b0, 16'h2222, '0);
    wait_idle();

    // Single-entry cache: repeated hits on one key
    write_capacity(1);
    queue_req(1'b1, 16'h7777, 32'hCAFE_F00D);
    queue_req(1'b0, 16'h7777, '0);
    queue_req(1'b0, 16'h7777, '0);
    wait_idle();

    foreach (caps[j]) begin
      write_capacity(caps[j]);
      if (j == 2) hold_go = 1'b1;
      random_phase(115);
      wait_idle();
    end

    if (errors == 0) $display("lfu_heap_cache_tb OK");
    else $display("lfu_heap_cache_tb NOT OK");
    $finish;
  end
endmodule

FILE: lfu_heap_cache.f
src/lhc_pkg.sv
src/lhc_if.sv
src/lhc_ram.sv
src/lhc_datapath.sv
src/lhc_ctrl.sv
src/lfu_heap_cache.sv
tb/lfu_heap_cache_tb.sv
